// ===== sv/assert_macros.svh =====
// Assertion macros used by the deframer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, suspended during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on clk, active during reset as well
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lpfr_pkg.sv =====
// Constants and types for the length-prefixed frame receiver
package lpfr_pkg;

  localparam int unsigned LEN_W   = 16;
  localparam int unsigned PADDR_W = 3;

  localparam logic [7:0] HDR_FIRST  = 8'hFA;
  localparam logic [7:0] HDR_SECOND = 8'hFB;
  localparam logic [7:0] TRL_FIRST  = 8'hEA;
  localparam logic [7:0] TRL_SECOND = 8'hE1;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 16'd1023;

  // Register word index taken from paddr[2]
  localparam logic REG_MAX_PAYLOAD = 1'b0;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_BAD_TRL1 = 2'd1;
  localparam logic [1:0] ST_BAD_TRL2 = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       last_payload;
    logic [1:0] frame_status;
  } result_t;

endpackage

// ===== sv/lpfr_if.sv =====
// Stream interfaces for received bytes and deframed results
interface lpfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfr_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       last_payload;
  logic [1:0] frame_status;

  modport source (output valid, output kind, output data_byte, output last_payload,
                  output frame_status, input ready);
  modport sink   (input valid, input kind, input data_byte, input last_payload,
                  input frame_status, output ready);
endinterface

// ===== sv/lpfr_cfg_regs.sv =====
// APB register block holding the maximum payload length
module lpfr_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [lpfr_pkg::LEN_W-1:0]  max_payload
);
  import lpfr_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      max_payload <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_MAX_PAYLOAD) begin
      prdata = {{(32-LEN_W){1'b0}}, max_payload};
    end
  end

  // paddr[1:0] only selects bytes within the word
  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule

// ===== sv/lpfr_deframer.sv =====
// Input register, deframing state machine and result register
module lpfr_deframer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lpfr_pkg::LEN_W-1:0] max_payload,
  lpfr_rx_if.sink                    rx,
  lpfr_res_if.source                 result
);
  import lpfr_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_HDR2   = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_DATA   = 3'd4,
    PH_TRL1   = 3'd5,
    PH_TRL2   = 3'd6
  } phase_t;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] bytes_seen, bytes_seen_next;
  logic             in_full;
  logic [7:0]       in_byte;
  logic             out_valid, out_valid_next;
  result_t          res, res_next;
  logic             emit;
  logic             advance;

  // Process the held request once the result register is free or draining
  assign advance  = in_full && (!out_valid || result.ready);
  assign rx.ready = !in_full || advance;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    emit              = 1'b0;
    res_next          = '0;
    unique case (phase)
      PH_HUNT: begin
        if (in_byte == HDR_FIRST) phase_next = PH_HDR2;
      end
      PH_HDR2: begin
        phase_next = (in_byte == HDR_SECOND) ? PH_LEN_HI : PH_HUNT;
      end
      PH_LEN_HI: begin
        frame_length_next = {{(LEN_W-8){1'b0}}, in_byte};
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_next = {frame_length[7:0], in_byte};
        bytes_seen_next   = '0;
        if (frame_length_next > max_payload) begin
          phase_next            = PH_HUNT;
          emit                  = 1'b1;
          res_next.kind         = KIND_END;
          res_next.frame_status = ST_TOO_LONG;
        end else if (frame_length_next == '0) begin
          phase_next = PH_TRL1;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        bytes_seen_next       = bytes_seen + 1'b1;
        emit                  = 1'b1;
        res_next.kind         = KIND_PAYLOAD;
        res_next.data_byte    = in_byte;
        res_next.last_payload = (bytes_seen_next == frame_length);
        if (res_next.last_payload) phase_next = PH_TRL1;
      end
      PH_TRL1: begin
        if (in_byte == TRL_FIRST) begin
          phase_next = PH_TRL2;
        end else begin
          phase_next            = PH_HUNT;
          emit                  = 1'b1;
          res_next.kind         = KIND_END;
          res_next.frame_status = ST_BAD_TRL1;
        end
      end
      PH_TRL2: begin
        phase_next            = PH_HUNT;
        emit                  = 1'b1;
        res_next.kind         = KIND_END;
        res_next.frame_status = (in_byte == TRL_SECOND) ? ST_GOOD : ST_BAD_TRL2;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_comb begin
    if (advance) begin
      out_valid_next = emit;
    end else begin
      out_valid_next = out_valid && !result.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= '0;
      bytes_seen   <= '0;
      in_full      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (rx.valid && rx.ready) begin
        in_full <= 1'b1;
        in_byte <= rx.rx_byte;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        phase        <= phase_next;
        frame_length <= frame_length_next;
        bytes_seen   <= bytes_seen_next;
        if (emit) res <= res_next;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.kind         = res.kind;
  assign result.data_byte    = res.data_byte;
  assign result.last_payload = res.last_payload;
  assign result.frame_status = res.frame_status;

  `ASSERT_CLK(a_data_count, (phase == PH_DATA) |-> (bytes_seen < frame_length), "payload count overran frame length")
  `ASSERT_CLK(a_last_to_trl, (advance && phase == PH_DATA && res_next.last_payload) |=> (phase == PH_TRL1), "last payload byte did not move to trailer check")
  `ASSERT_CLK(a_res_fields, out_valid |-> ((res.kind == KIND_END && res.data_byte == 8'd0 && !res.last_payload) || (res.kind == KIND_PAYLOAD && res.frame_status == ST_GOOD)), "result fields inconsistent with kind")
  `ASSERT_ALWAYS(a_rst_clear, rst |=> (!in_full && !out_valid && phase == PH_HUNT), "reset did not clear control state")

endmodule

// ===== sv/length_prefixed_frame_receiver_unit.sv =====
// Top level of the length-prefixed frame receiver
//
//   port      direction  carries
//   rx        sink       one received serial byte per request
//   result    source     payload byte or frame end with status
//   apb       slave      max_payload register at byte address 0
//
// One byte is accepted per cycle when the result side keeps up; each byte passes
// through the input register and then the result register before its result.
// Header, high length, in-range low length and good first trailer bytes produce no result.
// A stalled result holds the single input register; rx.ready drops only when
// both stages are full and the result is not taken. Synchronous active-high
// reset returns to header hunt and sets max_payload to 1023.
module length_prefixed_frame_receiver_unit (
  input  logic                         clk,
  input  logic                         rst,
  lpfr_rx_if.sink                      rx,
  lpfr_res_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lpfr_pkg::*;

  logic [LEN_W-1:0] max_payload;

  lpfr_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  lpfr_deframer u_deframer (
    .clk         (clk),
    .rst         (rst),
    .max_payload (max_payload),
    .rx          (rx),
    .result      (result)
  );

endmodule
